[design/psl_pkg.sv]
// ============================================================================
// psl_pkg
// Shared types and codes for the positional sequence list block.
// ============================================================================
package psl_pkg;

    localparam int ValueWidth    = 32;
    localparam int PositionWidth = 8;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT    = 3'd0,
        ACT_INSERT_AT     = 3'd1,
        ACT_PUSH_BACK     = 3'd2,
        ACT_POP_FRONT     = 3'd3,
        ACT_DELETE_MIDDLE = 3'd4,
        ACT_POP_BACK      = 3'd5,
        ACT_LIST_ALL      = 3'd6,
        ACT_UPDATE_AT     = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_ITEM     = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]                      action;
        logic signed [ValueWidth-1:0]    value;
        logic [PositionWidth-1:0]        position;
    } s_payload_t;

    typedef struct packed {
        logic [2:0]                      status;
        logic signed [ValueWidth-1:0]    item;
        logic                            last;
    } m_payload_t;

    // Controller to datapath.
    typedef struct packed {
        logic exec;   // apply the presented operation and load its status
        logic emit;   // load the front cell as a listed item and rotate
        logic last;   // marks the listed item as the final one
    } psl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic list_start;  // presented operation is a listing of a non-empty list
    } psl_sts_t;

endpackage

[design/psl_ctrl.sv]
// ============================================================================
// psl_ctrl
// Controller: accepts operations, sequences listings and owns the result
// channel's valid flag.
// ============================================================================
module psl_ctrl
    import psl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    input  psl_sts_t                            sts,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    output psl_cmd_t                            cmd
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t          state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (sts.list_start) begin
                        state_next = S_LIST;
                        idx_next   = '0;
                    end else begin
                        cmd.exec     = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_LIST: begin
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.last     = (idx_reg == count - CW'(1));
                    m_valid_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    if (cmd.last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

[design/psl_datapath.sv]
// ============================================================================
// psl_datapath
// Datapath: a chain of shifting cells holding the sequence, the element
// count, operation decode and the result payload register.
// ============================================================================
module psl_datapath
    import psl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  s_payload_t                          s_data,
    input  psl_cmd_t                            cmd,
    output psl_sts_t                            sts,
    output logic [$clog2(CAPACITY+1)-1:0]       count,
    output m_payload_t                          m_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [ValueWidth-1:0]  cells_reg  [CAPACITY];
    logic signed [ValueWidth-1:0]  cells_next [CAPACITY];
    logic [CW-1:0]                 count_reg, count_next;
    m_payload_t                    out_reg, out_next;

    logic [PositionWidth:0]        pos9, cnt9, upd9;
    logic [CW-1:0]                 slot;
    logic                          ins_en, del_en, popb_en, upd_en;
    logic [2:0]                    op_status;

    assign count  = count_reg;
    assign m_data = out_reg;
    assign pos9   = {1'b0, s_data.position};
    assign cnt9   = (PositionWidth+1)'(count_reg);
    assign upd9   = (s_data.position == '0) ? (PositionWidth+1)'(1) : pos9;

    // Operation decode.
    always_comb begin
        ins_en         = 1'b0;
        del_en         = 1'b0;
        popb_en        = 1'b0;
        upd_en         = 1'b0;
        slot           = '0;
        op_status      = ST_OK;
        sts.list_start = 1'b0;
        case (action_t'(s_data.action))
            ACT_PUSH_FRONT: begin
                ins_en = 1'b1;
            end
            ACT_INSERT_AT: begin
                ins_en = 1'b1;
                if (pos9 <= (PositionWidth+1)'(1) || count_reg == '0) begin
                    slot = '0;
                end else if (pos9 - (PositionWidth+1)'(1) >= cnt9) begin
                    slot = count_reg;
                end else begin
                    slot = CW'(pos9 - (PositionWidth+1)'(1));
                end
            end
            ACT_PUSH_BACK: begin
                ins_en = 1'b1;
                slot   = count_reg;
            end
            ACT_POP_FRONT: begin
                if (count_reg == '0) begin
                    op_status = ST_EMPTY;
                end else begin
                    del_en = 1'b1;
                end
            end
            ACT_DELETE_MIDDLE: begin
                if (pos9 <= (PositionWidth+1)'(1) || count_reg < CW'(2)) begin
                    op_status = ST_INVALID;
                end else if (pos9 < cnt9) begin
                    del_en = 1'b1;
                    slot   = CW'(pos9 - (PositionWidth+1)'(1));
                end else begin
                    op_status = ST_NOTFOUND;
                end
            end
            ACT_POP_BACK: begin
                if (count_reg == '0) begin
                    op_status = ST_EMPTY;
                end else begin
                    popb_en = 1'b1;
                end
            end
            ACT_LIST_ALL: begin
                if (count_reg == '0) begin
                    op_status = ST_EMPTY;
                end else begin
                    sts.list_start = 1'b1;
                end
            end
            ACT_UPDATE_AT: begin
                if (upd9 <= cnt9) begin
                    upd_en = 1'b1;
                    slot   = CW'(upd9 - (PositionWidth+1)'(1));
                end else begin
                    op_status = ST_NOTFOUND;
                end
            end
            default: begin
                op_status = ST_OK;
            end
        endcase
        if (ins_en && count_reg == CW'(CAPACITY)) begin
            ins_en    = 1'b0;
            op_status = ST_FULL;
        end
    end

    // Cell chain: each cell picks its own value, a neighbor, the front cell
    // or the new value.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cells_next[i] = cells_reg[i];
            if (cmd.exec && ins_en) begin
                if (CW'(i) == slot) begin
                    cells_next[i] = s_data.value;
                end else if (CW'(i) > slot) begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.exec && del_en) begin
                if (CW'(i) >= slot && i < CAPACITY - 1) begin
                    cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end else if (cmd.exec && upd_en) begin
                if (CW'(i) == slot) begin
                    cells_next[i] = s_data.value;
                end
            end else if (cmd.emit) begin
                // Rotate the occupied cells so the next element reaches the front.
                if (CW'(i) == count_reg - CW'(1)) begin
                    cells_next[i] = cells_reg[0];
                end else if (i < CAPACITY - 1) begin
                    cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        out_next   = out_reg;
        if (cmd.exec) begin
            if (ins_en) begin
                count_next = count_reg + CW'(1);
            end else if (del_en || popb_en) begin
                count_next = count_reg - CW'(1);
            end
            out_next.status = op_status;
            out_next.item   = '0;
            out_next.last   = 1'b1;
        end else if (cmd.emit) begin
            out_next.status = ST_ITEM;
            out_next.item   = cells_reg[0];
            out_next.last   = cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        for (int i = 0; i < CAPACITY; i++) begin
            cells_reg[i] <= cells_next[i];
        end
    end

endmodule

[design/positional_sequence_list.sv]
// ============================================================================
// positional_sequence_list
// Ordered list of signed 32-bit values with positional insert, delete,
// update and a streamed listing, held in a chain of shifting cells.
// ============================================================================
//
//   Channel   Ports                          Direction  Payload
//   input     s_valid, s_ready, s_data       in         action, value, position
//   result    m_valid, m_ready, m_data       out        status, item, last
//
// Every operation except a listing completes in the cycle of its transfer and
// presents its single status result on the next cycle; a new operation can
// be taken each cycle while the result register drains.
// A listing of N elements produces N results by rotating the cell chain, one per
// cycle unless the result stalls. The first listed item appears in the cycle after
// a status result would, and the input stays stalled until the last is emitted.
// Reset is synchronous and active low; it empties the list and drops any
// pending result. Cell contents are not cleared.
// A stalled result holds its payload and blocks new transfers on the input.
//
module positional_sequence_list
    import psl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  s_payload_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output m_payload_t  m_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Commands from the controller and status back from the datapath.
    psl_cmd_t       cmd;
    psl_sts_t       sts;
    logic [CW-1:0]  count;

    // The controller owns sequencing and the result valid flag.
    psl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .count   (count),
        .cmd     (cmd)
    );

    // The datapath holds the cells, the element count and the result payload.
    psl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .count   (count),
        .m_data  (m_data)
    );

endmodule

[tb/psl_check_pkg.sv]
`timescale 1ns / 100ps
// ============================================================================
// psl_check_pkg
// Scoreboard for the positional sequence list: keeps a shadow copy of the
// list, predicts the results of every accepted request, and checks each
// result transfer against the oldest prediction.
// ============================================================================
package psl_check_pkg;

    import psl_pkg::*;

    class list_scoreboard;

        int unsigned          capacity;
        logic signed [31:0]   shadow_list[$];
        m_payload_t           expected_replies[$];
        int unsigned          mismatches;

        function new(int unsigned depth);
            capacity   = depth;
            mismatches = 0;
        endfunction

        function int unsigned entries();
            return shadow_list.size();
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        function void push_status(status_t code);
            m_payload_t reply;
            reply.status = code;
            reply.item   = '0;
            reply.last   = 1'b1;
            expected_replies.push_back(reply);
        endfunction

        // A full list rejects the insert; a slot past the back appends.
        function void place_value(int unsigned slot, logic signed [31:0] val);
            if (shadow_list.size() >= capacity) begin
                push_status(ST_FULL);
            end else begin
                if (slot > shadow_list.size())
                    slot = shadow_list.size();
                shadow_list.insert(slot, val);
                push_status(ST_OK);
            end
        endfunction

        function void note_request(s_payload_t req);
            int unsigned cnt;
            int unsigned pos;
            m_payload_t  reply;
            cnt = shadow_list.size();
            pos = req.position;
            case (action_t'(req.action))
                ACT_PUSH_FRONT: begin
                    place_value(0, req.value);
                end
                ACT_INSERT_AT: begin
                    place_value((pos <= 1 || cnt == 0) ? 0 : pos - 1, req.value);
                end
                ACT_PUSH_BACK: begin
                    place_value(cnt, req.value);
                end
                ACT_POP_FRONT: begin
                    if (cnt == 0) begin
                        push_status(ST_EMPTY);
                    end else begin
                        shadow_list.delete(0);
                        push_status(ST_OK);
                    end
                end
                ACT_DELETE_MIDDLE: begin
                    if (pos <= 1 || cnt < 2) begin
                        push_status(ST_INVALID);
                    end else if (pos - 1 < cnt - 1) begin
                        shadow_list.delete(pos - 1);
                        push_status(ST_OK);
                    end else begin
                        push_status(ST_NOTFOUND);
                    end
                end
                ACT_POP_BACK: begin
                    if (cnt == 0) begin
                        push_status(ST_EMPTY);
                    end else begin
                        shadow_list.delete(cnt - 1);
                        push_status(ST_OK);
                    end
                end
                ACT_LIST_ALL: begin
                    if (cnt == 0) begin
                        push_status(ST_EMPTY);
                    end else begin
                        for (int unsigned i = 0; i < cnt; i++) begin
                            reply.status = ST_ITEM;
                            reply.item   = shadow_list[i];
                            reply.last   = (i == cnt - 1);
                            expected_replies.push_back(reply);
                        end
                    end
                end
                ACT_UPDATE_AT: begin
                    if (pos == 0)
                        pos = 1;
                    if (pos - 1 < cnt) begin
                        shadow_list[pos - 1] = req.value;
                        push_status(ST_OK);
                    end else begin
                        push_status(ST_NOTFOUND);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            $display("%0t ns: %s", $time, what);
        endfunction

        function void check_reply(m_payload_t got);
            m_payload_t want;
            if (expected_replies.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected: status %0d item %0d last %0b",
                                        got.status, got.item, got.last));
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status)
                note_mismatch($sformatf("status: expected %0d, actual %0d",
                                        want.status, got.status));
            if (got.item !== want.item)
                note_mismatch($sformatf("item: expected %0d, actual %0d",
                                        want.item, got.item));
            if (got.last !== want.last)
                note_mismatch($sformatf("last: expected %0b, actual %0b",
                                        want.last, got.last));
        endfunction

    endclass

endpackage

[tb/tb_positional_sequence_list.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_positional_sequence_list
// Self-checking bench for the positional sequence list. A directed opening
// walks through the edge cases of every operation, then random requests grow,
// churn and drain the list while both channels idle and stall at random.
// ============================================================================
module tb_positional_sequence_list;

    import psl_pkg::*;
    import psl_check_pkg::*;

    localparam int ListDepth    = 32;
    localparam int RandomCount  = 250;
    localparam int PhaseLength  = 50;

    // Mix of operations used in each stretch of the random traffic.
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_BALANCED,
        MIX_SHRINK
    } traffic_mix_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    s_payload_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    m_payload_t  m_data;

    list_scoreboard sb = new(ListDepth);

    positional_sequence_list #(
        .CAPACITY (ListDepth)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop. The slowest legal run (every request a full listing, every
    // result behind the longest stall) stays well inside this bound.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle length between transfers: mostly back to back, sometimes a short
    // pause, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Values lean toward the extremes of the signed range part of the time.
    function automatic logic signed [31:0] random_value();
        if ($urandom_range(0, 99) < 20) begin
            case ($urandom_range(0, 4))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Most positions land in or just past the list so that the positional
    // operations actually hit elements; the rest cover the whole byte.
    function automatic logic [7:0] random_position();
        if ($urandom_range(0, 99) < 75)
            return 8'($urandom_range(0, sb.entries() + 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic action_t random_action(traffic_mix_t mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (roll < 26)      return ACT_PUSH_FRONT;
                else if (roll < 52) return ACT_INSERT_AT;
                else if (roll < 78) return ACT_PUSH_BACK;
                else if (roll < 86) return ACT_UPDATE_AT;
                else if (roll < 92) return ACT_LIST_ALL;
                else if (roll < 95) return ACT_POP_FRONT;
                else if (roll < 98) return ACT_DELETE_MIDDLE;
                else                return ACT_POP_BACK;
            end
            MIX_SHRINK: begin
                if (roll < 24)      return ACT_POP_FRONT;
                else if (roll < 47) return ACT_POP_BACK;
                else if (roll < 70) return ACT_DELETE_MIDDLE;
                else if (roll < 80) return ACT_INSERT_AT;
                else if (roll < 90) return ACT_UPDATE_AT;
                else                return ACT_LIST_ALL;
            end
            default: begin
                return action_t'($urandom_range(0, 7));
            end
        endcase
    endfunction

    // Presents one request and returns at the edge where it is taken. The
    // valid line drops only when a gap precedes the request, so it is never
    // lowered and raised within one time step. The scoreboard learns of the
    // request at the very edge of its transfer, before its result can appear.
    task automatic send_request(action_t act, logic signed [31:0] val, logic [7:0] pos);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data.action   <= act;
        s_data.value    <= val;
        s_data.position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request('{action: act, value: val, position: pos});
    endtask

    // Result side: ready toggles in bursts, with occasional long stretches of
    // steady readiness and occasional long stalls. Ready is only lowered when
    // a nonzero stall is drawn.
    initial begin
        int unsigned burst;
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            burst = ($urandom_range(0, 99) < 10) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 12);
            stall = idle_gap();
            m_ready <= 1'b1;
            repeat (burst) @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Every result transfer is checked at the edge where it happens.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_reply(m_data);
    end

    initial begin
        traffic_mix_t mix;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Operations on an empty list: each answers with its empty-case status.
        send_request(ACT_LIST_ALL,      32'sd0,          8'd0);
        send_request(ACT_POP_FRONT,     32'sd0,          8'd0);
        send_request(ACT_POP_BACK,      32'sd0,          8'd0);
        send_request(ACT_DELETE_MIDDLE, 32'sd0,          8'd2);
        send_request(ACT_UPDATE_AT,     32'sd5,          8'd0);

        // Inserts: on an empty list any position means the front, a position
        // of zero means the front, and a position far past the back appends.
        send_request(ACT_INSERT_AT,     32'sd17,         8'd5);
        send_request(ACT_PUSH_BACK,     32'sh7FFF_FFFF,  8'd0);
        send_request(ACT_PUSH_FRONT,    32'sh8000_0000,  8'd0);
        send_request(ACT_INSERT_AT,     -32'sd1,         8'd0);
        send_request(ACT_INSERT_AT,     32'sd0,          8'd255);
        send_request(ACT_INSERT_AT,     32'sh5A5A_5A5A,  8'd3);

        // Middle delete: both front positions are invalid, the back element
        // and anything past it are not found, an inner position succeeds.
        send_request(ACT_DELETE_MIDDLE, 32'sd0,          8'd1);
        send_request(ACT_DELETE_MIDDLE, 32'sd0,          8'd0);
        send_request(ACT_DELETE_MIDDLE, 32'sd0,          8'd255);
        send_request(ACT_DELETE_MIDDLE, 32'sd0,          8'd6);
        send_request(ACT_DELETE_MIDDLE, 32'sd0,          8'd2);

        // Update: position zero aliases the front, the back is reachable,
        // one past the back and the top of the range are not found.
        send_request(ACT_UPDATE_AT,     32'shA5A5_A5A5,  8'd0);
        send_request(ACT_UPDATE_AT,     32'sh7FFF_FFFE,  8'd5);
        send_request(ACT_UPDATE_AT,     32'sd9,          8'd6);
        send_request(ACT_UPDATE_AT,     32'sd9,          8'd255);

        send_request(ACT_LIST_ALL,      32'sd0,          8'd0);
        send_request(ACT_POP_FRONT,     32'sd0,          8'd0);
        send_request(ACT_POP_BACK,      32'sd0,          8'd0);
        send_request(ACT_LIST_ALL,      32'sd0,          8'd0);

        // Random traffic in stretches: the growth stretches drive the list
        // into its full state, the shrink stretches back down to empty.
        for (int unsigned n = 0; n < RandomCount; n++) begin
            case ((n / PhaseLength) % 5)
                0, 3:    mix = MIX_GROW;
                1:       mix = MIX_BALANCED;
                default: mix = MIX_SHRINK;
            endcase
            send_request(random_action(mix), random_value(), random_position());
        end
        s_valid <= 1'b0;

        // Drain every predicted result, then leave room for any stray extra.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/psl_pkg.sv
design/psl_ctrl.sv
design/psl_datapath.sv
design/positional_sequence_list.sv
tb/psl_check_pkg.sv
tb/tb_positional_sequence_list.sv
